/* rtl/core/pcksum_pkg.sv */
// ----------------------------------------------------------------------------
// pcksum_pkg
// Shared types, constants and the CRC byte update for the cksum block.
// ----------------------------------------------------------------------------
package pcksum_pkg;

	// width of the running byte count; 8 to 64
	localparam int COUNT_BITS = 64;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [31:0] checksum;
		logic [63:0] byte_count;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_FOLD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;  // beat accepted: take byte (if any) and count it
		logic fold_step;  // fold one length byte into the CRC
		logic emit;       // latch result, clear CRC and count
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic left_zero;  // no length bytes remain to fold
	} status_t;

	// MSB-first CRC-32 update by one byte, eight shift steps
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h0};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* rtl/core/pcksum_ctrl.sv */
// ----------------------------------------------------------------------------
// pcksum_ctrl
// Sequencer: takes beats, runs the length fold, owns the result valid.
// ----------------------------------------------------------------------------
module pcksum_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_eos,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	output pcksum_pkg::cmd_t    cmd,
	input  pcksum_pkg::status_t status
);
	import pcksum_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign slot_free    = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.load_item = 1'b0;
		cmd.fold_step = 1'b0;
		cmd.emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					if (item_eos)
						state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (!status.left_zero) begin
					cmd.fold_step = 1'b1;
				end else if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/core/pcksum_dp.sv */
// ----------------------------------------------------------------------------
// pcksum_dp
// Datapath: running CRC, byte count, fold shifter and result register.
// ----------------------------------------------------------------------------
module pcksum_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pcksum_pkg::item_t   item,
	input  pcksum_pkg::cmd_t    cmd,
	output pcksum_pkg::status_t status,
	output pcksum_pkg::result_t result
);
	import pcksum_pkg::*;

	logic [31:0]           crc_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] left_q;
	result_t               result_q;

	logic [31:0]           crc_n;
	logic [COUNT_BITS-1:0] cnt_n;

	always_comb begin
		crc_n = item.has_data ? crc_feed(crc_q, item.data_byte) : crc_q;
		cnt_n = item.has_data ? cnt_q + COUNT_BITS'(1) : cnt_q;
	end

	assign status.left_zero = (left_q == '0);
	assign result           = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			cnt_q <= '0;
		end else begin
			priority if (cmd.load_item) begin
				crc_q <= crc_n;
				cnt_q <= cnt_n;
			end else if (cmd.fold_step) begin
				crc_q <= crc_feed(crc_q, left_q[7:0]);
			end else if (cmd.emit) begin
				crc_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	// length bytes go in LSB first until nothing is left
	always_ff @(posedge clk) begin
		if (cmd.load_item)
			left_q <= cnt_n;
		else if (cmd.fold_step)
			left_q <= left_q >> 8;
		if (cmd.emit) begin
			result_q.checksum   <= ~crc_q;
			result_q.byte_count <= 64'(cnt_q);
		end
	end

endmodule

/* rtl/core/posix_cksum_crc32.sv */
// ----------------------------------------------------------------------------
// posix_cksum_crc32
// Stream checksum as computed by POSIX cksum: CRC-32 plus byte count.
//
// A data beat (has_data set, end_of_stream clear) is taken every cycle while
// no fold runs. A beat with end_of_stream set (with or without a byte) starts
// the length fold: the byte count is fed into the CRC one byte per cycle, LSB
// first, until the remaining count is zero, so the end beat holds the input
// off until its result is latched. Only significant count bytes are folded
// (none for an empty stream, at most COUNT_BITS/8), through a byte-wide CRC
// update apart from the one for data bytes. The result sits in an output
// register; new data beats are taken while it waits, and a following end beat
// finishes its fold only once the previous result has been taken.
// ----------------------------------------------------------------------------
module posix_cksum_crc32 (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  pcksum_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output pcksum_pkg::result_t result
);
	import pcksum_pkg::*;

	cmd_t    cmd;
	status_t status;

	pcksum_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_eos     (item.end_of_stream),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	pcksum_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule
